// ===== src/sorted_key_table_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Sorted key table assertion macros
// Shared property forms for the checker of the sorted key table unit.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_UNIT_MACROS_SVH
`define SORTED_KEY_TABLE_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SKT_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: property violated");

// next-cycle implication, disabled during reset
`define SKT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: property violated");

// value in the cycle after reset is applied
`define SKT_ASSERT_RESET(name, cons) \
  name: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("%m: reset value violated");

`endif

// ===== src/skt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key table package
// Word types, operation codes, status codes and controller states.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int FUNC_W   = 2;
  localparam int KEY_W    = 31;
  localparam int HANDLE_W = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_FIND   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_DELETE = 2'd2;
  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_DUP,
    ST_NOTFOUND,
    ST_FULL
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_UP,
    S_INS,
    S_DOWN,
    S_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] payload_handle;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] found_handle;
    logic [COUNT_W-1:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic push;
    rsp_t word;
  } result_t;

endpackage

// ===== src/skt_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key table stream interface
// Valid/ready channel carrying one word per handshake.
// ----------------------------------------------------------------------------
interface skt_stream_if #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/skt_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key table memory
// Entry storage with one write port and one registered read port.
// ----------------------------------------------------------------------------
module skt_mem import skt_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/skt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key table controller
// Scans the table in order, then for an insert or delete shifts entries up or down one per cycle.
// ----------------------------------------------------------------------------
module skt_ctrl import skt_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  req_t          req_word,
  output logic          req_ready,
  input  logic          out_free,
  output result_t       result,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output entry_t        wr_data,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  input  entry_t        rd_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] ZERO       = '0;
  localparam logic [CW-1:0] ONE        = CW'(1);
  localparam logic [CW-1:0] TWO        = CW'(2);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  ctrl_state_t         state, state_next;
  logic [CW-1:0]       fill, fill_next;
  logic [CW-1:0]       ptr, ptr_next;
  logic [CW-1:0]       j, j_next;
  req_t                op, op_next;
  logic                hit, hit_next;
  logic [HANDLE_W-1:0] hit_handle, hit_handle_next;
  status_t             res_status, res_status_next;
  logic [HANDLE_W-1:0] res_handle, res_handle_next;

  logic          known_func;
  logic          key_less;
  logic          key_equal;
  logic [CW-1:0] ptr_inc;
  logic [CW-1:0] fill_inc;
  logic [CW-1:0] fill_dec;
  logic [CW-1:0] j_inc;
  logic [CW-1:0] j_inc2;
  logic [CW-1:0] j_dec;
  logic [CW-1:0] j_dec2;
  entry_t        new_entry;

  assign known_func = (req_word.func == FN_INSERT) || (req_word.func == FN_FIND) ||
                      (req_word.func == FN_DELETE);
  assign key_less  = rd_data.key < op.key;
  assign key_equal = rd_data.key == op.key;
  assign ptr_inc   = ptr + ONE;
  assign fill_inc  = fill + ONE;
  assign fill_dec  = fill - ONE;
  assign j_inc     = j + ONE;
  assign j_inc2    = j + TWO;
  assign j_dec     = j - ONE;
  assign j_dec2    = j - TWO;
  assign new_entry = '{key: op.key, handle: op.payload_handle};

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (fill == ZERO || !known_func) begin
            state_next = S_EVAL;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (!key_less || ptr_inc == fill) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        state_next = S_OUT;
        case (op.func)
          FN_INSERT: begin
            if (!hit && fill != FULL_COUNT && ptr != fill) begin
              state_next = S_UP;
            end
          end
          FN_DELETE: begin
            if (hit && ptr_inc != fill) begin
              state_next = S_DOWN;
            end
          end
          default: ;
        endcase
      end
      S_UP: begin
        if (j_dec == ptr) begin
          state_next = S_INS;
        end
      end
      S_INS: begin
        state_next = S_OUT;
      end
      S_DOWN: begin
        if (j_inc2 == fill) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    fill_next       = fill;
    ptr_next        = ptr;
    j_next          = j;
    op_next         = op;
    hit_next        = hit;
    hit_handle_next = hit_handle;
    res_status_next = res_status;
    res_handle_next = res_handle;
    wr_en           = 1'b0;
    wr_addr         = j[AW-1:0];
    wr_data         = rd_data;
    rd_en           = 1'b0;
    rd_addr         = '0;
    req_ready       = (state == S_IDLE) && !rst;
    result.push     = 1'b0;
    result.word     = '{status: res_status, found_handle: res_handle,
                        entry_count: COUNT_W'(fill)};
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          op_next         = req_word;
          ptr_next        = ZERO;
          hit_next        = 1'b0;
          hit_handle_next = '0;
          rd_en           = 1'b1;
        end
      end
      S_SCAN: begin
        if (key_less) begin
          if (ptr_inc == fill) begin
            ptr_next = fill;
          end else begin
            ptr_next = ptr_inc;
            rd_en    = 1'b1;
            rd_addr  = ptr_inc[AW-1:0];
          end
        end else begin
          hit_next        = key_equal;
          hit_handle_next = rd_data.handle;
        end
      end
      S_EVAL: begin
        res_status_next = ST_NOTFOUND;
        res_handle_next = '0;
        case (op.func)
          FN_INSERT: begin
            if (hit) begin
              res_status_next = ST_DUP;
            end else if (fill == FULL_COUNT) begin
              res_status_next = ST_FULL;
            end else begin
              res_status_next = ST_OK;
              if (ptr == fill) begin
                wr_en     = 1'b1;
                wr_addr   = ptr[AW-1:0];
                wr_data   = new_entry;
                fill_next = fill_inc;
              end else begin
                rd_en   = 1'b1;
                rd_addr = fill_dec[AW-1:0];
                j_next  = fill;
              end
            end
          end
          FN_FIND: begin
            if (hit) begin
              res_status_next = ST_OK;
              res_handle_next = hit_handle;
            end
          end
          FN_DELETE: begin
            if (hit) begin
              res_status_next = ST_OK;
              if (ptr_inc == fill) begin
                fill_next = fill_dec;
              end else begin
                rd_en   = 1'b1;
                rd_addr = ptr_inc[AW-1:0];
                j_next  = ptr;
              end
            end
          end
          default: ;
        endcase
      end
      S_UP: begin
        wr_en   = 1'b1;
        wr_addr = j[AW-1:0];
        if (j_dec != ptr) begin
          rd_en   = 1'b1;
          rd_addr = j_dec2[AW-1:0];
          j_next  = j_dec;
        end
      end
      S_INS: begin
        wr_en     = 1'b1;
        wr_addr   = ptr[AW-1:0];
        wr_data   = new_entry;
        fill_next = fill_inc;
      end
      S_DOWN: begin
        wr_en   = 1'b1;
        wr_addr = j[AW-1:0];
        if (j_inc2 == fill) begin
          fill_next = fill_dec;
        end else begin
          rd_en   = 1'b1;
          rd_addr = j_inc2[AW-1:0];
          j_next  = j_inc;
        end
      end
      S_OUT: begin
        result.push = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= ZERO;
    end else begin
      state <= state_next;
      fill  <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    j          <= j_next;
    op         <= op_next;
    hit        <= hit_next;
    hit_handle <= hit_handle_next;
    res_status <= res_status_next;
    res_handle <= res_handle_next;
  end

endmodule

// ===== src/sorted_key_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key table unit
// Table of up to DEPTH keys with payload handles, kept in ascending order.
// ----------------------------------------------------------------------------
// Each request word carries insert, find or delete and returns one response
// word with a status, the found handle and the entry count after the
// operation. The table sits in one memory with a registered read port; the
// controller walks it one entry per cycle, scanning up to the slot of the key
// for every operation and then, for an insert or delete, shifting the
// entries behind that slot. An unknown operation or an empty table skips the
// scan. The response is held in an output register, so the next request is
// taken while a finished response waits. The table is empty after reset; no
// clearing pass is run.
module sorted_key_table_unit import skt_pkg::*; #(
  parameter int DEPTH = 16
) (
  input logic          clk,
  input logic          rst,
  skt_stream_if.sink   req,
  skt_stream_if.source rsp
);

  localparam int AW = $clog2(DEPTH);

  result_t       result;
  logic          out_free;
  logic          rsp_valid;
  rsp_t          rsp_word;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;

  assign out_free  = !rsp_valid || rsp.ready;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_word;

  skt_ctrl #(.DEPTH(DEPTH), .AW(AW)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_word  (req.data),
    .req_ready (req.ready),
    .out_free  (out_free),
    .result    (result),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  skt_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (result.push) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.push) begin
      rsp_word <= result.word;
    end
  end

endmodule

// ===== src/skt_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key table checker
// Port-level properties of the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_key_table_unit_macros.svh"

module skt_chk import skt_pkg::*; #(
  parameter int DEPTH = 16
) (
  input logic                clk,
  input logic                rst,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [STATUS_W-1:0] rsp_status,
  input logic [HANDLE_W-1:0] rsp_handle,
  input logic [COUNT_W-1:0]  rsp_count
);

  logic [STATUS_W+HANDLE_W+COUNT_W-1:0] rsp_fields;

  assign rsp_fields = {rsp_status, rsp_handle, rsp_count};

  `SKT_ASSERT_RESET(a_reset_idle, !rsp_valid)
  `SKT_ASSERT_NEXT(a_stall_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_fields))
  `SKT_ASSERT_SAME(a_handle_ok, rsp_valid && rsp_handle != '0, rsp_status == ST_OK)
  `SKT_ASSERT_SAME(a_full_count, rsp_valid && rsp_status == ST_FULL, rsp_count == COUNT_W'(DEPTH))
  `SKT_ASSERT_SAME(a_count_bound, rsp_valid, (DEPTH > 31) || (rsp_count <= COUNT_W'(DEPTH)))

endmodule

bind sorted_key_table_unit skt_chk #(.DEPTH(DEPTH)) u_skt_chk (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.data.status),
  .rsp_handle (rsp.data.found_handle),
  .rsp_count  (rsp.data.entry_count)
);

// ===== test/skt_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key table checker
// Watches the request and response channels of the sorted key table unit and
// keeps its own copy of the table. Each accepted request word is applied to
// that copy to predict the response word. Each accepted response word is
// compared field by field with the oldest prediction. Mismatches and
// unexpected responses are counted and handed to the top.
// ----------------------------------------------------------------------------
module skt_table_checker import skt_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req_word,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp_word,
  output int   fail_count,
  output int   pending_count
);

  logic [KEY_W-1:0]    key_tab    [DEPTH];
  logic [HANDLE_W-1:0] handle_tab [DEPTH];
  int unsigned         fill;
  rsp_t                expected_rsp [$];
  int                  errors;

  initial begin
    fill          = 0;
    errors        = 0;
    fail_count    = 0;
    pending_count = 0;
  end

  function automatic rsp_t apply_table_op(req_t r);
    rsp_t        o;
    int unsigned pos;
    logic        hit;
    pos = 0;
    while (pos < fill && key_tab[pos] < r.key) pos++;
    hit            = (pos < fill) && (key_tab[pos] == r.key);
    o.status       = ST_NOTFOUND;
    o.found_handle = '0;
    case (r.func)
      FN_INSERT: begin
        if (hit) begin
          o.status = ST_DUP;
        end else if (fill >= DEPTH) begin
          o.status = ST_FULL;
        end else begin
          for (int i = fill; i > pos; i--) begin
            key_tab[i]    = key_tab[i-1];
            handle_tab[i] = handle_tab[i-1];
          end
          key_tab[pos]    = r.key;
          handle_tab[pos] = r.payload_handle;
          fill++;
          o.status = ST_OK;
        end
      end
      FN_FIND: begin
        if (hit) begin
          o.status       = ST_OK;
          o.found_handle = handle_tab[pos];
        end
      end
      FN_DELETE: begin
        if (hit) begin
          for (int i = pos; i + 1 < fill; i++) begin
            key_tab[i]    = key_tab[i+1];
            handle_tab[i] = handle_tab[i+1];
          end
          fill--;
          o.status = ST_OK;
        end
      end
      default: ;
    endcase
    o.entry_count = fill[COUNT_W-1:0];
    return o;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      fill = 0;
      expected_rsp.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp.size() == 0) begin
          $error("response word with no request outstanding");
          errors++;
        end else begin
          want = expected_rsp.pop_front();
          check_field("status", want.status, rsp_word.status);
          check_field("found_handle", want.found_handle, rsp_word.found_handle);
          check_field("entry_count", want.entry_count, rsp_word.entry_count);
        end
      end
      if (req_valid && req_ready) expected_rsp.push_back(apply_table_op(req_word));
    end
    fail_count    <= errors;
    pending_count <= expected_rsp.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key table testbench
// Drives the sorted key table unit with a directed sequence covering empty,
// full, duplicate and missing-key cases, then with random insert, find and
// delete words over a small key pool so that hits, misses and a full table
// all occur often. Both channel sides stall at random. The checker beside
// the block predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module testbench import skt_pkg::*;;

  localparam int DEPTH       = 16;
  localparam int RAND_ITEMS  = 900;
  localparam int POOL_SIZE   = 24;
  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst;
  logic calm;
  int   fail_count;
  int   pending_count;
  int   cycles;

  skt_stream_if #(.word_t(req_t)) req_ch ();
  skt_stream_if #(.word_t(rsp_t)) rsp_ch ();

  sorted_key_table_unit #(.DEPTH(DEPTH)) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  skt_table_checker #(.DEPTH(DEPTH)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_ch.valid),
    .req_ready     (req_ch.ready),
    .req_word      (req_ch.data),
    .rsp_valid     (rsp_ch.valid),
    .rsp_ready     (rsp_ch.ready),
    .rsp_word      (rsp_ch.data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    calm         = 1'b0;
    cycles       = 0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rsp_ch.ready = 1'b0;
  end

  always #5 clk = ~clk;

  always @(negedge clk) begin
    rsp_ch.ready <= calm || ($urandom_range(99) >= 9);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic req_t make_req(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k,
                                    logic [HANDLE_W-1:0] h);
    req_t r;
    r.func           = f;
    r.key            = k;
    r.payload_handle = h;
    return r;
  endfunction

  // caller sits at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input req_t w);
    while (!calm && $urandom_range(99) < 9) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= w;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  initial begin
    logic [KEY_W-1:0]    key_pool [POOL_SIZE];
    logic [FUNC_W-1:0]   f;
    logic [KEY_W-1:0]    k;
    int                  r;
    bit                  insert_heavy;
    req_t                directed [$];

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    directed.push_back(make_req(FN_FIND, 31'd5, 16'h0000));
    directed.push_back(make_req(FN_DELETE, 31'd5, 16'h0000));
    directed.push_back(make_req(FN_UNUSED, 31'h7FFF_FFFF, 16'hFFFF));
    directed.push_back(make_req(FN_INSERT, 31'd0, 16'h0000));
    directed.push_back(make_req(FN_DELETE, 31'd7, 16'h1234));
    directed.push_back(make_req(FN_FIND, 31'd9, 16'h0000));
    directed.push_back(make_req(FN_INSERT, 31'h7FFF_FFFF, 16'hFFFF));
    directed.push_back(make_req(FN_INSERT, 31'd0, 16'hAAAA));
    directed.push_back(make_req(FN_FIND, 31'd0, 16'h0000));
    directed.push_back(make_req(FN_FIND, 31'h7FFF_FFFF, 16'h0000));
    directed.push_back(make_req(FN_FIND, 31'd100, 16'h0000));
    for (int j = 14; j >= 1; j--)
      directed.push_back(make_req(FN_INSERT, 31'(100 * j), 16'($urandom)));
    directed.push_back(make_req(FN_INSERT, 31'd50, 16'h5555));
    directed.push_back(make_req(FN_INSERT, 31'd0, 16'h5555));
    directed.push_back(make_req(FN_FIND, 31'd700, 16'h0000));
    directed.push_back(make_req(FN_DELETE, 31'd300, 16'h0000));
    directed.push_back(make_req(FN_DELETE, 31'h7FFF_FFFF, 16'h0000));
    directed.push_back(make_req(FN_DELETE, 31'd0, 16'h0000));
    directed.push_back(make_req(FN_UNUSED, 31'd200, 16'h0000));
    foreach (directed[i]) send_word(directed[i]);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 120 == 0) begin
        for (int p = 0; p < POOL_SIZE; p++) begin
          r = $urandom_range(9);
          if (r == 0)      key_pool[p] = '0;
          else if (r == 1) key_pool[p] = 31'h7FFF_FFFF;
          else if (r < 5)  key_pool[p] = 31'($urandom_range(64));
          else             key_pool[p] = 31'($urandom);
        end
        insert_heavy = ((i / 120) % 2) == 0;
      end
      calm = (i >= 400 && i < 550);
      r = $urandom_range(99);
      if (r < 3)                           f = FN_UNUSED;
      else if (r < (insert_heavy ? 60 : 25)) f = FN_INSERT;
      else if (r < (insert_heavy ? 80 : 55)) f = FN_FIND;
      else                                 f = FN_DELETE;
      if ($urandom_range(99) < 90) k = key_pool[$urandom_range(POOL_SIZE - 1)];
      else                         k = 31'($urandom);
      send_word(make_req(f, k, 16'($urandom)));
    end
    calm = 1'b0;
    req_ch.valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/skt_pkg.sv
src/skt_stream_if.sv
src/skt_mem.sv
src/skt_ctrl.sv
src/sorted_key_table_unit.sv
src/skt_chk.sv
test/skt_table_checker.sv
test/testbench.sv
